FILE: design/modexp_pkg.sv
package modexp_pkg;

  // Width of each operand field on the stream ports
  localparam int FIELD_W = 64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DECIDE,
    ST_MUL,
    ST_SQUARE,
    ST_FINISH
  } modexp_state_t;

endpackage

FILE: design/modular_exponentiation_unit.sv
// Modular exponentiation, base ** exponent mod modulus, by right-to-left square and
// multiply. Each input item carries base, exponent and modulus (only the low WIDTH bits
// of each are used) and gives exactly one result item. All modular products run on one
// shared bit-serial multiplier: the base is first reduced by the modulus, then every
// set exponent bit costs one multiply into the accumulator and every exponent bit above
// the lowest costs one square, each followed by a step in ST_DECIDE. A zero exponent
// needs only the reduction. A zero modulus skips the products and returns 0 with the
// error flag in tuser set. The block takes one item at a time; in_tready is high only
// when the sequencer is idle, and a finished result waits in an output register so the
// next item can be accepted before it is taken.
module modular_exponentiation_unit
  import modexp_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata: base [63:0], exponent [127:64], modulus [191:128]
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3*FIELD_W-1:0] in_tdata,
  // out_tdata: power_mod [63:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [FIELD_W-1:0]   out_tdata,
  // out_tuser: zero_modulus [0]
  output logic                 out_tuser
);

  localparam int CNT_W = $clog2(WIDTH);

  modexp_state_t state_r, state_nxt;

  logic [WIDTH-1:0] mod_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] sq_r;
  logic [WIDTH-1:0] exp_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] r_r;
  logic [CNT_W-1:0] cnt_r;
  logic             zero_r;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_data_r;
  logic               out_err_r;

  logic [WIDTH-1:0] in_base;
  logic [WIDTH-1:0] in_exp;
  logic [WIDTH-1:0] in_mod;
  logic             in_fire;
  logic             slot_free;

  logic             unit_busy;
  logic             unit_last;
  logic [WIDTH-1:0] unit_x;
  logic [WIDTH+1:0] unit_sum;
  logic [WIDTH+1:0] unit_m1;
  logic [WIDTH+1:0] unit_m2;
  logic [WIDTH+1:0] unit_sel;
  logic [WIDTH-1:0] unit_res;

  // Operand fields, taken modulo 2^WIDTH
  assign in_base = in_tdata[WIDTH-1:0];
  assign in_exp  = in_tdata[FIELD_W +: WIDTH];
  assign in_mod  = in_tdata[2*FIELD_W +: WIDTH];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // Control decode: which product the shared unit is forming
  always_comb begin
    unit_busy = 1'b0;
    unit_x    = sq_r;
    unique case (state_r)
      ST_REDUCE: begin
        unit_busy = 1'b1;
        unit_x    = WIDTH'(1);
      end
      ST_MUL: begin
        unit_busy = 1'b1;
        unit_x    = acc_r;
      end
      ST_SQUARE: begin
        unit_busy = 1'b1;
        unit_x    = sq_r;
      end
      default: begin
        unit_busy = 1'b0;
        unit_x    = sq_r;
      end
    endcase
  end

  assign unit_last = (cnt_r == '0);

  // Shared modular multiply step: r = (2r + ybit * x) mod m, with r, x < m
  always_comb begin
    unit_sum = {1'b0, r_r, 1'b0} + (y_r[WIDTH-1] ? {2'b00, unit_x} : '0);
    unit_m1  = {2'b00, mod_r};
    unit_m2  = {1'b0, mod_r, 1'b0};
    if (unit_sum >= unit_m2) begin
      unit_sel = unit_sum - unit_m2;
    end else if (unit_sum >= unit_m1) begin
      unit_sel = unit_sum - unit_m1;
    end else begin
      unit_sel = unit_sum;
    end
    unit_res = unit_sel[WIDTH-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_mod == '0) ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE, ST_MUL, ST_SQUARE: begin
        if (unit_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (exp_r == '0) begin
          state_nxt = ST_FINISH;
        end else if (exp_r[0]) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand load, unit iteration and write-back
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mod_r  <= in_mod;
      exp_r  <= in_exp;
      y_r    <= in_base;
      r_r    <= '0;
      cnt_r  <= CNT_W'(WIDTH - 1);
      zero_r <= (in_mod == '0);
      acc_r  <= (in_mod == '0 || in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else if (unit_busy) begin
      r_r   <= unit_res;
      y_r   <= {y_r[WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
      if (unit_last) begin
        if (state_r == ST_MUL) begin
          acc_r <= unit_res;
          exp_r <= {exp_r[WIDTH-1:1], 1'b0};
        end else begin
          sq_r <= unit_res;
        end
      end
    end else if (state_r == ST_DECIDE) begin
      // set up the next product; an even exponent moves on to the next square
      r_r   <= '0;
      cnt_r <= CNT_W'(WIDTH - 1);
      y_r   <= sq_r;
      if (!exp_r[0]) begin
        exp_r <= exp_r >> 1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && slot_free) begin
      out_data_r <= FIELD_W'(acc_r);
      out_err_r  <= zero_r;
    end
  end

endmodule
